@@ rtl/core/ats_pkg.sv @@
package ats_pkg;

    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;

    // cordic angle accumulator, radians with 23 fraction bits
    localparam int ANGLE_W = 26;

    localparam int GAIN_SHIFT     = 12;
    localparam int COEF_SHIFT     = 12;
    localparam int VOL_SHIFT      = 16;
    localparam int THRESH_FRAC    = 23;
    localparam int WET_SHIFT_BASE = 35;
    localparam int BLEND_FULL     = 100;

    // divide by 100 one radix-256 digit at a time
    localparam int DIV_DIGIT_W     = 8;
    localparam int DIV_REM_W       = 7;
    localparam int DIV_PROD_W      = 28;
    localparam int DIV_RECIP       = 5243;
    localparam int DIV_RECIP_SHIFT = 19;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_OPERATE_MODE   = 3'd0,
        CFG_INPUT_GAIN     = 3'd1,
        CFG_SAT_COEF       = 3'd2,
        CFG_NEG_SCALE      = 3'd3,
        CFG_CLIP_THRESHOLD = 3'd4,
        CFG_BLEND_PERCENT  = 3'd5,
        CFG_VOLUME         = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic        operate_mode;
        logic [21:0] input_gain;
        logic [14:0] sat_coef;
        logic [15:0] neg_scale;
        logic [23:0] clip_threshold;
        logic [6:0]  blend_percent;
        logic [16:0] volume;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        operate_mode:   1'b0,
        input_gain:     22'd4096,
        sat_coef:       15'd4096,
        neg_scale:      16'd5215,
        clip_threshold: 24'd8388608,
        blend_percent:  7'd0,
        volume:         17'd65
    };

    // atan(2^-i)
    function automatic logic signed [ANGLE_W-1:0] atan_angle(input int idx);
        case (idx)
            0:       return 26'sd6588397;
            1:       return 26'sd3889358;
            2:       return 26'sd2055030;
            3:       return 26'sd1043165;
            4:       return 26'sd523607;
            5:       return 26'sd262059;
            6:       return 26'sd131061;
            7:       return 26'sd65535;
            8:       return 26'sd32768;
            9:       return 26'sd16384;
            10:      return 26'sd8192;
            11:      return 26'sd4096;
            12:      return 26'sd2048;
            13:      return 26'sd1024;
            default: return '0;
        endcase
    endfunction

endpackage

@@ rtl/core/asymmetric_saturator_blend_core.sv @@
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_ready    i_left_sample, i_right_sample
// out       output     o_out_valid / i_out_ready  o_out_left, o_out_right
// cfg       input      i_cfg_wr_en                i_cfg_index, i_cfg_data
//
// one word per cycle sustained while i_out_ready is high; the pipeline depth is set by
// the front stages, the cordic stages, the divide-by-100 digit stages and the mix stages
// every stage has its own valid and loads when empty or when the next stage moves,
// so bubbles close up and a stalled output still lets new words in
// synchronous active-low reset clears all valid bits and loads register defaults
module asymmetric_saturator_blend_core #(
    parameter int SAMPLE_BITS     = 24,
    parameter int ATAN_TABLE_BITS = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [ats_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [ats_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]     i_left_sample,
    input  logic signed [SAMPLE_BITS-1:0]     i_right_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]     o_out_left,
    output logic signed [SAMPLE_BITS-1:0]     o_out_right
);
    import ats_pkg::*;

    localparam int TAG_W = 2 * (SAMPLE_BITS + 5) + 2;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_OPERATE_MODE:   r_cfg.operate_mode   <= i_cfg_data[0];
                CFG_INPUT_GAIN:     r_cfg.input_gain     <= i_cfg_data[21:0];
                CFG_SAT_COEF:       r_cfg.sat_coef       <= i_cfg_data[14:0];
                CFG_NEG_SCALE:      r_cfg.neg_scale      <= i_cfg_data[15:0];
                CFG_CLIP_THRESHOLD: r_cfg.clip_threshold <= i_cfg_data[23:0];
                CFG_BLEND_PERCENT:  r_cfg.blend_percent  <= i_cfg_data[6:0];
                CFG_VOLUME:         r_cfg.volume         <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    logic                          fr_valid;
    logic                          fr_ready;
    logic signed [SAMPLE_BITS+8:0] fr_arg;
    logic [TAG_W-1:0]              fr_tag;
    logic                          cd_valid;
    logic                          cd_ready;
    logic signed [ANGLE_W-1:0]     cd_theta;
    logic [TAG_W-1:0]              cd_tag;

    ats_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_left  (i_left_sample),
        .i_right (i_right_sample),
        .o_valid (fr_valid),
        .i_ready (fr_ready),
        .o_arg   (fr_arg),
        .o_tag   (fr_tag)
    );

    ats_cordic #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .ATAN_TABLE_BITS (ATAN_TABLE_BITS),
        .TAG_W           (TAG_W)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (fr_ready),
        .i_arg   (fr_arg),
        .i_tag   (fr_tag),
        .o_valid (cd_valid),
        .i_ready (cd_ready),
        .o_theta (cd_theta),
        .o_tag   (cd_tag)
    );

    ats_mix #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (cd_valid),
        .o_ready (cd_ready),
        .i_theta (cd_theta),
        .i_tag   (cd_tag),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_left  (o_out_left),
        .o_right (o_out_right)
    );

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid right after reset");

endmodule

@@ rtl/core/ats_front.sv @@
module ats_front #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ats_pkg::t_cfg                 i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_left,
    input  logic signed [SAMPLE_BITS-1:0] i_right,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS+8:0] o_arg,
    output logic [2*SAMPLE_BITS+11:0]     o_tag
);
    import ats_pkg::*;

    localparam int SB   = SAMPLE_BITS;
    localparam int GW   = SB + 5;
    localparam int FRAC = SB - 1;
    localparam int NS   = 3;

    localparam logic signed [GW-1:0] G_HI = {1'b0, {(GW-1){1'b1}}};
    localparam logic signed [GW-1:0] G_LO = {1'b1, {(GW-1){1'b0}}};
    localparam logic signed [SB-1:0] S_HI = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] S_LO = {1'b1, {(SB-1){1'b0}}};

    logic [NS-1:0] r_vld;
    logic [NS:0]   adv;
    logic [NS-1:0] vld_in;

    assign adv[NS]  = i_ready;
    assign adv[0]   = !r_vld[0] || adv[1];
    assign adv[1]   = !r_vld[1] || adv[2];
    assign adv[2]   = !r_vld[2] || adv[3];
    assign vld_in   = {r_vld[NS-2:0], i_valid};
    assign o_ready  = adv[0];
    assign o_valid  = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= vld_in[k];
                end
            end
        end
    end

    // stage 0: input products
    logic signed [17:0]    vol_s;
    logic signed [22:0]    gain_s;
    logic signed [SB+17:0] n0_pl;
    logic signed [SB+17:0] n0_pr;
    logic signed [SB+22:0] n0_pg;
    logic signed [SB+17:0] r0_pl;
    logic signed [SB+17:0] r0_pr;
    logic signed [SB+22:0] r0_pg;
    logic                  r0_mode;

    assign vol_s  = {1'b0, i_cfg.volume};
    assign gain_s = {1'b0, i_cfg.input_gain};
    assign n0_pl  = i_left * vol_s;
    assign n0_pr  = i_right * vol_s;
    assign n0_pg  = i_left * gain_s;

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r0_pl   <= n0_pl;
            r0_pr   <= n0_pr;
            r0_pg   <= n0_pg;
            r0_mode <= i_cfg.operate_mode;
        end
    end

    // stage 1: gained sample clamp, bypass saturation
    logic signed [SB+10:0] gs;
    logic signed [SB+1:0]  pls;
    logic signed [SB+1:0]  prs;
    logic signed [GW-1:0]  n1_g;
    logic signed [SB-1:0]  n1_bl;
    logic signed [SB-1:0]  n1_br;
    logic signed [GW-1:0]  r1_g;
    logic signed [SB-1:0]  r1_bl;
    logic signed [SB-1:0]  r1_br;
    logic                  r1_mode;

    assign gs  = r0_pg[SB+22:GAIN_SHIFT];
    assign pls = r0_pl[SB+17:VOL_SHIFT];
    assign prs = r0_pr[SB+17:VOL_SHIFT];

    always_comb begin
        if (&gs[SB+10:GW-1] || ~|gs[SB+10:GW-1]) begin
            n1_g = gs[GW-1:0];
        end else begin
            n1_g = gs[SB+10] ? G_LO : G_HI;
        end
        if (&pls[SB+1:SB-1] || ~|pls[SB+1:SB-1]) begin
            n1_bl = pls[SB-1:0];
        end else begin
            n1_bl = pls[SB+1] ? S_LO : S_HI;
        end
        if (&prs[SB+1:SB-1] || ~|prs[SB+1:SB-1]) begin
            n1_br = prs[SB-1:0];
        end else begin
            n1_br = prs[SB+1] ? S_LO : S_HI;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r1_g    <= n1_g;
            r1_bl   <= n1_bl;
            r1_br   <= n1_br;
            r1_mode <= r0_mode;
        end
    end

    // stage 2: cordic argument, positive hard clip
    logic signed [15:0]      sat_s;
    logic signed [SB+20:0]   prod_a;
    logic [23+FRAC:0]        th_full;
    logic [23+FRAC:0]        th_sh;
    logic signed [GW-1:0]    tg;
    logic                    pos;
    logic signed [GW-1:0]    wp;
    logic [2*GW+1:0]         n2_tag;
    logic signed [SB+8:0]    r2_arg;
    logic [2*GW+1:0]         r2_tag;

    assign sat_s   = {1'b0, i_cfg.sat_coef};
    assign prod_a  = r1_g * sat_s;
    assign th_full = {i_cfg.clip_threshold, {FRAC{1'b0}}};
    assign th_sh   = th_full >> THRESH_FRAC;
    assign tg      = {5'b0, th_sh[SB-1:0]};
    assign pos     = !r1_g[GW-1] && (|r1_g);
    assign wp      = (r1_g > tg) ? tg : r1_g;

    // bypass words ride in the g and clip fields of the tag
    always_comb begin
        if (r1_mode) begin
            n2_tag = {1'b1, pos, r1_g, wp};
        end else begin
            n2_tag = {1'b0, 1'b0, {{5{r1_bl[SB-1]}}, r1_bl}, {{5{r1_br[SB-1]}}, r1_br}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r2_arg <= prod_a[SB+20:COEF_SHIFT];
            r2_tag <= n2_tag;
        end
    end

    assign o_arg = r2_arg;
    assign o_tag = r2_tag;

endmodule

@@ rtl/core/ats_cordic.sv @@
module ats_cordic #(
    parameter int SAMPLE_BITS     = 24,
    parameter int ATAN_TABLE_BITS = 10,
    parameter int TAG_W           = 60
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [SAMPLE_BITS+8:0]       i_arg,
    input  logic [TAG_W-1:0]                    i_tag,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [ats_pkg::ANGLE_W-1:0]  o_theta,
    output logic [TAG_W-1:0]                    o_tag
);
    import ats_pkg::*;

    localparam int NS = ATAN_TABLE_BITS;
    localparam int CW = SAMPLE_BITS + 10;

    // x starts at 1.0
    localparam logic signed [CW-1:0] X_INIT = {{10{1'b0}}, 1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic [NS-1:0] r_vld;
    logic [NS:0]   adv;
    logic [NS-1:0] vld_in;

    logic signed [CW-1:0]      r_x   [NS];
    logic signed [CW-1:0]      r_y   [NS];
    logic signed [ANGLE_W-1:0] r_z   [NS];
    logic [TAG_W-1:0]          r_tag [NS];

    assign adv[NS] = i_ready;
    assign vld_in  = {r_vld[NS-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= vld_in[k];
                end
            end
        end
    end

    genvar i;
    for (i = 0; i < NS; i++) begin : g_iter
        logic signed [CW-1:0]      px;
        logic signed [CW-1:0]      py;
        logic signed [ANGLE_W-1:0] pz;
        logic [TAG_W-1:0]          ptag;
        logic signed [CW-1:0]      xs;
        logic signed [CW-1:0]      ys;
        logic signed [CW-1:0]      n_x;
        logic signed [CW-1:0]      n_y;
        logic signed [ANGLE_W-1:0] n_z;

        if (i == 0) begin : g_first
            assign px   = X_INIT;
            assign py   = {i_arg[SAMPLE_BITS+8], i_arg};
            assign pz   = '0;
            assign ptag = i_tag;
        end else begin : g_next
            assign px   = r_x[i-1];
            assign py   = r_y[i-1];
            assign pz   = r_z[i-1];
            assign ptag = r_tag[i-1];
        end

        assign xs     = px >>> i;
        assign ys     = py >>> i;
        assign adv[i] = !r_vld[i] || adv[i+1];

        // rotate toward y = 0
        always_comb begin
            if (py[CW-1]) begin
                n_x = px - ys;
                n_y = py + xs;
                n_z = pz - atan_angle(i);
            end else begin
                n_x = px + ys;
                n_y = py - xs;
                n_z = pz + atan_angle(i);
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv[i]) begin
                r_x[i]   <= n_x;
                r_y[i]   <= n_y;
                r_z[i]   <= n_z;
                r_tag[i] <= ptag;
            end
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_vld[NS-1];
    assign o_theta = r_z[NS-1];
    assign o_tag   = r_tag[NS-1];

    a_first_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && !adv[1]) |=> (r_vld[0] && $stable(r_tag[0])))
        else $error("cordic first stage lost or changed a stalled word");

endmodule

@@ rtl/core/ats_mix.sv @@
module ats_mix #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ats_pkg::t_cfg                       i_cfg,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [ats_pkg::ANGLE_W-1:0]  i_theta,
    input  logic [2*SAMPLE_BITS+11:0]           i_tag,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [SAMPLE_BITS-1:0]       o_left,
    output logic signed [SAMPLE_BITS-1:0]       o_right
);
    import ats_pkg::*;

    localparam int SB        = SAMPLE_BITS;
    localparam int GW        = SB + 5;
    localparam int NW        = GW + 8;
    localparam int NDIG      = (NW + DIV_DIGIT_W - 1) / DIV_DIGIT_W;
    localparam int MW        = NDIG * DIV_DIGIT_W;
    localparam int VW        = DIV_REM_W + DIV_DIGIT_W;
    localparam int WET_SHIFT = WET_SHIFT_BASE - (SB - 1);
    localparam int NS        = NDIG + 4;
    localparam int ST_MUL    = NDIG + 2;
    localparam int ST_OUT    = NDIG + 3;

    localparam logic signed [SB-1:0] S_HI = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] S_LO = {1'b1, {(SB-1){1'b0}}};

    logic [NS-1:0] r_vld;
    logic [NS:0]   adv;
    logic [NS-1:0] vld_in;

    assign adv[NS] = i_ready;
    assign vld_in  = {r_vld[NS-2:0], i_valid};

    genvar k;
    for (k = 0; k < NS; k++) begin : g_adv
        assign adv[k] = !r_vld[k] || adv[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < NS; s++) begin
                if (adv[s]) begin
                    r_vld[s] <= vld_in[s];
                end
            end
        end
    end

    // stage 0: scale the arctangent into the wet word, or pass the clip for positive words
    logic                           t_mode;
    logic                           t_pos;
    logic signed [GW-1:0]           t_g;
    logic signed [GW-1:0]           t_w;
    logic signed [16:0]             nsc_s;
    logic signed [ANGLE_W+16:0]     prod_w;
    logic signed [GW-1:0]           wet_neg;
    logic signed [GW-1:0]           r0_wet;
    logic signed [GW-1:0]           r0_g;
    logic signed [GW-1:0]           r0_w;
    logic                           r0_mode;

    assign t_mode  = i_tag[2*GW+1];
    assign t_pos   = i_tag[2*GW];
    assign t_g     = i_tag[2*GW-1:GW];
    assign t_w     = i_tag[GW-1:0];
    assign nsc_s   = {1'b0, i_cfg.neg_scale};
    assign prod_w  = nsc_s * i_theta;
    assign wet_neg = prod_w[WET_SHIFT+GW-1:WET_SHIFT];

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r0_wet  <= t_pos ? t_w : wet_neg;
            r0_g    <= t_g;
            r0_w    <= t_w;
            r0_mode <= t_mode;
        end
    end

    // stage 1: weighted sum, split into sign and magnitude
    logic [6:0]           b7;
    logic [6:0]           nb7;
    logic signed [7:0]    b_s;
    logic signed [7:0]    nb_s;
    logic signed [NW-1:0] n1_wb;
    logic signed [NW-1:0] n1_gb;
    logic signed [NW-1:0] n1_sum;
    logic [NW-1:0]        n1_mag;
    logic                 r1_sign;
    logic [MW-1:0]        r1_mag;
    logic                 r1_mode;
    logic signed [SB-1:0] r1_bl;
    logic signed [SB-1:0] r1_br;

    assign b7     = (i_cfg.blend_percent > 7'(BLEND_FULL)) ? 7'(BLEND_FULL) : i_cfg.blend_percent;
    assign nb7    = 7'(BLEND_FULL) - b7;
    assign b_s    = {1'b0, b7};
    assign nb_s   = {1'b0, nb7};
    assign n1_wb  = r0_wet * b_s;
    assign n1_gb  = r0_g * nb_s;
    assign n1_sum = n1_wb + n1_gb;
    assign n1_mag = n1_sum[NW-1] ? -n1_sum : n1_sum;

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r1_sign <= n1_sum[NW-1];
            r1_mag  <= MW'(n1_mag);
            r1_mode <= r0_mode;
            r1_bl   <= r0_g[SB-1:0];
            r1_br   <= r0_w[SB-1:0];
        end
    end

    // digit stages: magnitude / 100, most significant digit first
    logic [MW-1:0]          r_dm    [NDIG];
    logic [MW-1:0]          r_dq    [NDIG];
    logic [DIV_REM_W-1:0]   r_drem  [NDIG];
    logic                   r_dsign [NDIG];
    logic                   r_dmode [NDIG];
    logic signed [SB-1:0]   r_dbl   [NDIG];
    logic signed [SB-1:0]   r_dbr   [NDIG];

    genvar j;
    for (j = 0; j < NDIG; j++) begin : g_digit
        logic [MW-1:0]           pm;
        logic [MW-1:0]           pq;
        logic [DIV_REM_W-1:0]    prem;
        logic                    psign;
        logic                    pmode;
        logic signed [SB-1:0]    pbl;
        logic signed [SB-1:0]    pbr;
        logic [VW-1:0]           v;
        logic [DIV_PROD_W-1:0]   qp;
        logic [DIV_DIGIT_W-1:0]  qd;
        logic [VW-1:0]           qx;
        logic [VW-1:0]           remw;
        logic [MW-1:0]           n_q;

        if (j == 0) begin : g_first
            assign pm    = r1_mag;
            assign pq    = '0;
            assign prem  = '0;
            assign psign = r1_sign;
            assign pmode = r1_mode;
            assign pbl   = r1_bl;
            assign pbr   = r1_br;
        end else begin : g_next
            assign pm    = r_dm[j-1];
            assign pq    = r_dq[j-1];
            assign prem  = r_drem[j-1];
            assign psign = r_dsign[j-1];
            assign pmode = r_dmode[j-1];
            assign pbl   = r_dbl[j-1];
            assign pbr   = r_dbr[j-1];
        end

        // v < 25600, reciprocal is exact over that range
        assign v    = {prem, pm[MW-1-DIV_DIGIT_W*j -: DIV_DIGIT_W]};
        assign qp   = DIV_PROD_W'(v) * DIV_PROD_W'(DIV_RECIP);
        assign qd   = qp[DIV_RECIP_SHIFT +: DIV_DIGIT_W];
        assign qx   = VW'(qd) * VW'(BLEND_FULL);
        assign remw = v - qx;

        always_comb begin
            n_q = pq;
            n_q[MW-1-DIV_DIGIT_W*j -: DIV_DIGIT_W] = qd;
        end

        always_ff @(posedge i_clk) begin
            if (adv[j+2]) begin
                r_dm[j]    <= pm;
                r_dq[j]    <= n_q;
                r_drem[j]  <= remw[DIV_REM_W-1:0];
                r_dsign[j] <= psign;
                r_dmode[j] <= pmode;
                r_dbl[j]   <= pbl;
                r_dbr[j]   <= pbr;
            end
        end
    end

    // volume multiply
    logic signed [GW:0]    qn;
    logic signed [GW:0]    mixv;
    logic signed [17:0]    vol_s;
    logic signed [SB+23:0] n2_prod;
    logic signed [SB+23:0] r2_prod;
    logic                  r2_mode;
    logic signed [SB-1:0]  r2_bl;
    logic signed [SB-1:0]  r2_br;

    assign qn      = {1'b0, r_dq[NDIG-1][GW-1:0]};
    assign mixv    = r_dsign[NDIG-1] ? -qn : qn;
    assign vol_s   = {1'b0, i_cfg.volume};
    assign n2_prod = mixv * vol_s;

    always_ff @(posedge i_clk) begin
        if (adv[ST_MUL]) begin
            r2_prod <= n2_prod;
            r2_mode <= r_dmode[NDIG-1];
            r2_bl   <= r_dbl[NDIG-1];
            r2_br   <= r_dbr[NDIG-1];
        end
    end

    // output register with final saturation
    logic signed [SB+7:0] rs;
    logic signed [SB-1:0] sat_o;
    logic signed [SB-1:0] r3_left;
    logic signed [SB-1:0] r3_right;
    logic                 r3_mode;

    assign rs = r2_prod[SB+23:VOL_SHIFT];

    always_comb begin
        if (&rs[SB+7:SB-1] || ~|rs[SB+7:SB-1]) begin
            sat_o = rs[SB-1:0];
        end else begin
            sat_o = rs[SB+7] ? S_LO : S_HI;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_OUT]) begin
            r3_left  <= r2_mode ? sat_o : r2_bl;
            r3_right <= r2_mode ? sat_o : r2_br;
            r3_mode  <= r2_mode;
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_vld[ST_OUT];
    assign o_left  = r3_left;
    assign o_right = r3_right;

    a_rem_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NDIG+1] |-> (r_drem[NDIG-1] < DIV_REM_W'(BLEND_FULL)))
        else $error("division remainder out of range");

    a_operate_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ST_OUT] && r3_mode) |-> (r3_left == r3_right))
        else $error("operate mode word differs between channels");

endmodule
